@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the keyed hash unit.
// Each macro expects a signal named clk in the enclosing scope; ASSERT_CLK also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/shk_pkg.sv @@
// Shared types, constants and round function for the SipHash-2-4 unit.
// Used by the front end, command queue, hash core and top level.
package shk_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned LEN_W     = 8;
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);
  localparam int unsigned OUT_DEPTH = 2;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0] MAGIC_0   = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] MAGIC_1   = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] MAGIC_2   = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] MAGIC_3   = 64'h7465646279746573;
  localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  // What the core does with one command.
  typedef enum logic [1:0] {
    OP_MID       = 2'd0,  // compress word
    OP_LAST_FULL = 2'd1,  // compress word, compress tail, finalize
    OP_LAST_PART = 2'd2   // compress word (already the padded tail), finalize
  } op_e_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] tail;
    logic              start;
    op_e_t             op;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } sip_state_t;

  function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] x);
    return {x[WORD_W-14:0], x[WORD_W-1:WORD_W-13]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl16(input logic [WORD_W-1:0] x);
    return {x[WORD_W-17:0], x[WORD_W-1:WORD_W-16]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl17(input logic [WORD_W-1:0] x);
    return {x[WORD_W-18:0], x[WORD_W-1:WORD_W-17]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl21(input logic [WORD_W-1:0] x);
    return {x[WORD_W-22:0], x[WORD_W-1:WORD_W-21]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x);
    return {x[WORD_W-33:0], x[WORD_W-1:WORD_W-32]};
  endfunction

  function automatic sip_state_t sip_mix_step(input sip_state_t v);
    sip_state_t r;
    r   = v;
    r.a = r.a + r.b;
    r.c = r.c + r.d;
    r.b = rotl13(r.b) ^ r.a;
    r.d = rotl16(r.d) ^ r.c;
    r.a = rotl32(r.a);
    r.c = r.c + r.b;
    r.a = r.a + r.d;
    r.b = rotl17(r.b) ^ r.c;
    r.d = rotl21(r.d) ^ r.a;
    r.c = rotl32(r.c);
    return r;
  endfunction

  function automatic sip_state_t sip_init(input logic [WORD_W-1:0] k0,
                                          input logic [WORD_W-1:0] k1);
    sip_state_t v;
    v.a = MAGIC_0 ^ k0;
    v.b = MAGIC_1 ^ k1;
    v.c = MAGIC_2 ^ k0;
    v.d = MAGIC_3 ^ k1;
    return v;
  endfunction

endpackage

@@ hw/rtl/shk_front.sv @@
// Front end: accepts message words, tracks length and message start,
// and turns each beat into one command for the hash core. Uses shk_pkg.
module shk_front
  import shk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic [WORD_W-1:0]  in_message_word,
  input  logic [COUNT_W-1:0] in_byte_count,
  input  logic               in_last_word,
  output logic               in_full,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               in_msg_r, in_msg_nxt;
  logic [LEN_W-1:0]   len_base;
  logic [COUNT_W-1:0] count_sat;
  logic [WORD_W-1:0]  masked;
  logic [WORD_W-1:0]  len_word;
  logic               accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept;

  always_comb begin
    len_base  = in_msg_r ? len_r : '0;
    count_sat = (in_byte_count > FULL_COUNT) ? FULL_COUNT : in_byte_count;
    if (in_last_word) begin
      len_nxt = len_base + LEN_W'(count_sat);
    end else begin
      len_nxt = len_base + LEN_W'(FULL_COUNT);
    end
    // Keep only the bytes below the count; the length goes in the top byte.
    for (int i = 0; i < WORD_W / 8; i++) begin
      masked[i*8 +: 8] = (COUNT_W'(i) < count_sat) ? in_message_word[i*8 +: 8] : 8'h00;
    end
    len_word = {len_nxt, {(WORD_W - LEN_W){1'b0}}};

    q_cmd.start = !in_msg_r;
    q_cmd.tail  = len_word;
    if (!in_last_word) begin
      q_cmd.op   = OP_MID;
      q_cmd.word = in_message_word;
    end else if (count_sat == FULL_COUNT) begin
      q_cmd.op   = OP_LAST_FULL;
      q_cmd.word = in_message_word;
    end else begin
      q_cmd.op   = OP_LAST_PART;
      q_cmd.word = masked ^ len_word;
    end

    in_msg_nxt = in_msg_r;
    if (accept) begin
      in_msg_nxt = !in_last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      in_msg_r <= 1'b0;
    end else if (accept) begin
      len_r    <= len_nxt;
      in_msg_r <= in_msg_nxt;
    end
  end

endmodule

@@ hw/rtl/shk_cmd_queue.sv @@
// Short command queue between the front end and the hash core.
// Holds CMD_DEPTH commands of type cmd_t from shk_pkg.
module shk_cmd_queue
  import shk_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t                 slot_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_CNT_W-1:0] count_r;
  logic                 do_push, do_pop;

  assign full    = (count_r == CMD_CNT_W'(CMD_DEPTH));
  assign valid   = (count_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ hw/rtl/shk_core.sv @@
// Hash core: one SipRound unit per cycle, driven by a small sequencer; the last
// round waits for room in the result queue toward the output ports. Uses shk_pkg.
module shk_core
  import shk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [WORD_W-1:0] key_low,
  input  logic [WORD_W-1:0] key_high,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output logic [WORD_W-1:0] out_hash_value
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_C1   = 4'b0010,  // second round of a compression
    ST_C0   = 4'b0100,  // first round of the length-word compression
    ST_FIN  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  sip_state_t        v_r, v_nxt;
  logic [WORD_W-1:0] m_r, m_nxt;
  logic [WORD_W-1:0] tail_r, tail_nxt;
  logic              second_r, second_nxt;
  logic              fin_r, fin_nxt;
  logic [1:0]        fcnt_r, fcnt_nxt;
  sip_state_t        round_in, round_out;
  logic              res_push;
  logic [WORD_W-1:0] res_hash;

  logic [WORD_W-1:0]    res_mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] res_wr_r, res_rd_r;
  logic [OUT_CNT_W-1:0] res_cnt_r;
  logic                 res_full, res_pop;

  assign round_out = sip_mix_step(round_in);
  assign res_hash  = round_out.a ^ round_out.b ^ round_out.c ^ round_out.d;
  assign res_full  = (res_cnt_r == OUT_CNT_W'(OUT_DEPTH));

  // Operand of the round unit for the current step.
  always_comb begin
    round_in = v_r;
    case (state_r)
      ST_IDLE: begin
        // The first round of a compression runs in the cycle the command is taken.
        round_in   = cmd.start ? sip_init(key_low, key_high) : v_r;
        round_in.d = round_in.d ^ cmd.word;
      end
      ST_C0: begin
        round_in.d = v_r.d ^ tail_r;
      end
      ST_FIN: begin
        if (fcnt_r == 2'd0) begin
          round_in.c = v_r.c ^ FINAL_XOR;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    v_nxt      = v_r;
    m_nxt      = m_r;
    tail_nxt   = tail_r;
    second_nxt = second_r;
    fin_nxt    = fin_r;
    fcnt_nxt   = fcnt_r;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          v_nxt      = round_out;
          m_nxt      = cmd.word;
          tail_nxt   = cmd.tail;
          second_nxt = (cmd.op == OP_LAST_FULL);
          fin_nxt    = (cmd.op != OP_MID);
          state_nxt  = ST_C1;
        end
      end
      ST_C1: begin
        v_nxt   = round_out;
        v_nxt.a = round_out.a ^ m_r;
        if (second_r) begin
          state_nxt = ST_C0;
        end else if (fin_r) begin
          fcnt_nxt  = '0;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_C0: begin
        v_nxt      = round_out;
        m_nxt      = tail_r;
        second_nxt = 1'b0;
        state_nxt  = ST_C1;
      end
      ST_FIN: begin
        // The last round waits until the result queue has room.
        if (!(fcnt_r == 2'd3 && res_full)) begin
          v_nxt    = round_out;
          fcnt_nxt = fcnt_r + 2'd1;
          if (fcnt_r == 2'd3) begin
            res_push  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    m_r    <= m_nxt;
    tail_r <= tail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      second_r <= 1'b0;
      fin_r    <= 1'b0;
      fcnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
      fin_r    <= fin_nxt;
      fcnt_r   <= fcnt_nxt;
    end
  end

  // Result queue.
  assign out_empty      = (res_cnt_r == '0);
  assign out_hash_value = res_mem_r[res_rd_r];
  assign res_pop        = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem_r[res_wr_r] <= res_hash;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= '0;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      if (res_push) begin
        res_wr_r <= res_wr_r + 1'b1;
      end
      if (res_pop) begin
        res_rd_r <= res_rd_r + 1'b1;
      end
      case ({res_push, res_pop})
        2'b10:   res_cnt_r <= res_cnt_r + 1'b1;
        2'b01:   res_cnt_r <= res_cnt_r - 1'b1;
        default: res_cnt_r <= res_cnt_r;
      endcase
    end
  end

endmodule

@@ hw/rtl/siphash_2_4_keyed_hash_unit.sv @@
// SipHash-2-4 keyed hash unit. Message words enter through a queue-style port;
// the front end pads the final word and queues up to four commands, so input
// beats are taken while the core is still working. One SipRound unit does one
// round per cycle, but the last finalization round waits while the result queue
// is full. A non-last word is compressed; a last word with fewer than 8 bytes is
// compressed and finalized (two compression and four finalization rounds); a last
// word with 8 bytes is compressed, then the length word, then finalized. The hash
// waits in a two-entry result queue. The key is written through the cfg port
// (index 0 low half, index 1 high half) and is read with each message's first word.
module siphash_2_4_keyed_hash_unit
  import shk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [WORD_W-1:0]    in_message_word,
  input  logic [COUNT_W-1:0]   in_byte_count,
  input  logic                 in_last_word,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [WORD_W-1:0]    out_hash_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  logic [WORD_W-1:0] key_low_r, key_high_r;
  logic              q_push, q_full, q_valid, q_pop;
  cmd_t              q_cmd, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low_r  <= cfg_data;
        REG_KEY_HIGH: key_high_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  shk_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_message_word (in_message_word),
    .in_byte_count   (in_byte_count),
    .in_last_word    (in_last_word),
    .in_full         (in_full),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  shk_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  shk_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .key_low        (key_low_r),
    .key_high       (key_high_r),
    .cmd_valid      (q_valid),
    .cmd            (q_head),
    .cmd_pop        (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_hash_value (out_hash_value)
  );

endmodule

@@ hw/rtl/shk_checker.sv @@
// Port-level checker for the keyed hash unit, bound to the top level.
// Depends on shk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module shk_checker
  import shk_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_full,
  input logic                 out_empty,
  input logic                 out_pop,
  input logic [WORD_W-1:0]    out_hash_value,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  // A waiting result beat stays put until it is popped.
  `ASSERT_CLK(a_out_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_hash_value)), "result beat changed before pop")

  // Reset leaves no result behind and room for input.
  `ASSERT_CLK(a_out_empty_after_reset, ($past(rst_n) == 1'b0) |-> out_empty, "result present right after reset")
  `ASSERT_CLK(a_in_room_after_reset, ($past(rst_n) == 1'b0) |-> !in_full, "input full right after reset")

  // No result appears while the unit is held in reset.
  `ASSERT_ALWAYS(a_empty_in_reset, (!rst_n) |=> (out_empty || rst_n), "result present while held in reset")

  // The key registers accept a write in every cycle.
  `ASSERT_CLK(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration write stalled")

endmodule

bind siphash_2_4_keyed_hash_unit shk_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_hash_value (out_hash_value),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);
